// ===== design/wrs_pkg.sv =====
// shared types, constants and a helper function for the windowed rate statistics unit
// no dependencies; imported by wrs_ctrl, wrs_dp and the top level
`timescale 1ns / 1ps

package wrs_pkg;

    localparam int WRS_WINDOW   = 64;
    localparam int CNT_W        = 64;
    localparam int RATE_W       = 32;
    localparam int SCALE_W      = 16;
    localparam int PROD_W       = RATE_W + SCALE_W;
    localparam int NUM_LANES    = 2;
    // two 16-bit quotient digits, each a reciprocal-multiply step then a back-multiply step
    localparam int AVG_STEPS    = 4;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_DATA_W    = NUM_LANES * CNT_W;
    localparam int OUT_DATA_W   = NUM_LANES * 4 * RATE_W;

    localparam logic [CFG_IDX_W-1:0]  REG_RATE_SCALE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0]  REG_GLOBAL_MAX = CFG_IDX_W'(1);
    localparam logic [SCALE_W-1:0]    RATE_SCALE_RST = SCALE_W'(256);
    localparam logic [RATE_W-1:0]     RATE_SAT       = '1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic mul_en;
        logic scale;
        logic scan;
        logic div_init;
        logic div_step;
        logic load_out;
    } wrs_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic primed;
        logic mul_last;
        logic scan_last;
        logic div_skip;
        logic div_last;
        logic out_free;
    } wrs_status_t;

    // combine the two 32x16 partial products into a saturated rate
    function automatic logic [RATE_W-1:0] scale_rate(input logic [PROD_W-1:0] lo_prod,
                                                     input logic [PROD_W-1:0] hi_prod);
        logic [56:0] prod;
        logic [48:0] quot;
        logic [RATE_W-1:0] res;
        prod = {1'b0, hi_prod[23:0], 32'b0} + {9'b0, lo_prod};
        quot = prod[56:8];
        if (hi_prod[PROD_W-1:24] != '0)
            res = RATE_SAT;
        else if (quot[48:32] != '0)
            res = RATE_SAT;
        else
            res = quot[31:0];
        return res;
    endfunction

endpackage

// ===== design/wrs_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module wrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/wrs_ctrl.sv =====
// sequencing state machine for the windowed rate statistics unit
// depends on wrs_pkg; drives the datapath through wrs_cmd_t
`timescale 1ns / 1ps

module wrs_ctrl
    import wrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    output wrs_cmd_t    cmd,
    input  wrs_status_t status
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_MUL     = 8'b0000_0010,
        ST_SCALE   = 8'b0000_0100,
        ST_SCAN    = 8'b0000_1000,
        ST_DRAIN   = 8'b0001_0000,
        ST_DIVINIT = 8'b0010_0000,
        ST_DIV     = 8'b0100_0000,
        ST_DONE    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    // first word only primes the previous snapshot
                    if (status.primed)
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (status.mul_last)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_DIVINIT;
            end
            ST_DIVINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = status.div_skip ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/wrs_dp.sv =====
// datapath: snapshot differences, rate scaling, history ram scan, averaging divider
// depends on wrs_pkg and wrs_ram; controlled by wrs_ctrl
`timescale 1ns / 1ps

module wrs_dp
    import wrs_pkg::*;
#(
    parameter int WINDOW = WRS_WINDOW
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  wrs_cmd_t              cmd,
    output wrs_status_t           status
);

    localparam int  AW      = $clog2(WINDOW);
    localparam int  LOGW    = $clog2(WINDOW);
    localparam int  SUM_W   = RATE_W + LOGW;
    localparam bit  IS_POW2 = ((WINDOW & (WINDOW - 1)) == 0);
    localparam int  MEM_W   = NUM_LANES * RATE_W;
    localparam int  DIG_W   = RATE_W / 2;
    localparam int  T_W     = LOGW + DIG_W;
    localparam int  RCP_SH  = T_W + LOGW;
    localparam int  PRD_W   = 2 * T_W + 1;
    // rounded-up reciprocal of WINDOW, exact for any numerator below 2^T_W
    localparam logic [T_W:0] RECIP = (T_W + 1)'((64'd1 << RCP_SH) / 64'(WINDOW) + 64'd1);

    // configuration
    logic [SCALE_W-1:0] rate_scale_reg;
    logic               global_max_reg;

    // snapshot and scaling
    logic               primed_reg;
    logic [CNT_W-1:0]   prev_reg [NUM_LANES];
    logic [CNT_W-1:0]   diff_reg [NUM_LANES];
    logic [1:0]         mul_cnt_reg;
    logic [PROD_W-1:0]  prod_reg [4];
    logic [RATE_W-1:0]  rate_reg [NUM_LANES];
    logic [RATE_W-1:0]  rate_new [NUM_LANES];
    logic [RATE_W-1:0]  mul_op;
    logic [PROD_W-1:0]  mul_res;

    // history
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW:0]        fill_reg;
    logic [AW-1:0]      scan_cnt_reg;
    logic               rd_v_reg;
    logic               rd_fill_reg;
    logic [MEM_W-1:0]   rd_data;
    logic [MEM_W-1:0]   wr_data;

    // statistics
    logic [RATE_W-1:0]  min_reg  [NUM_LANES];
    logic [RATE_W-1:0]  max_reg  [NUM_LANES];
    logic [RATE_W-1:0]  hold_reg [NUM_LANES];
    logic [SUM_W-1:0]   sum_reg  [NUM_LANES];
    logic [RATE_W-1:0]  hist_val [NUM_LANES];

    // divider: long division in 16-bit digits, reciprocal multiply then back-multiply
    logic [LOGW-1:0]    rem_reg  [NUM_LANES];
    logic [RATE_W-1:0]  quot_reg [NUM_LANES];
    logic [DIG_W-1:0]   qd_reg   [NUM_LANES];
    logic [T_W-1:0]     div_num  [NUM_LANES];
    logic [PRD_W-1:0]   div_prod [NUM_LANES];
    logic [T_W-1:0]     div_back [NUM_LANES];
    logic [T_W-1:0]     div_rem  [NUM_LANES];
    logic [1:0]         div_cnt_reg;

    // output register
    logic               m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_scale_reg <= RATE_SCALE_RST;
            global_max_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_RATE_SCALE)
                rate_scale_reg <= cfg_data;
            else if (cfg_index == REG_GLOBAL_MAX)
                global_max_reg <= cfg_data[0];
        end
    end

    // shared 32x16 multiplier: rx lo, rx hi, tx lo, tx hi
    assign mul_op  = mul_cnt_reg[0] ? diff_reg[mul_cnt_reg[1]][CNT_W-1:RATE_W]
                                    : diff_reg[mul_cnt_reg[1]][RATE_W-1:0];
    assign mul_res = PROD_W'(mul_op) * PROD_W'(rate_scale_reg);

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            rate_new[l] = scale_rate(prod_reg[2 * l], prod_reg[2 * l + 1]);
            hist_val[l] = rd_fill_reg ? rd_data[l * RATE_W +: RATE_W] : '0;
            // partial remainder followed by the next dividend digit
            div_num[l]  = {rem_reg[l], quot_reg[l][RATE_W-1 -: DIG_W]};
            div_prod[l] = PRD_W'(div_num[l]) * PRD_W'(RECIP);
            div_back[l] = T_W'(qd_reg[l]) * T_W'(WINDOW);
            div_rem[l]  = div_num[l] - div_back[l];
        end
    end

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            wr_data[l * RATE_W +: RATE_W] = rate_new[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg  <= 1'b0;
            mul_cnt_reg <= '0;
            wr_ptr_reg  <= '0;
            fill_reg    <= '0;
            scan_cnt_reg <= '0;
            rd_v_reg    <= 1'b0;
            div_cnt_reg <= '0;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                prev_reg[l] <= '0;
                hold_reg[l] <= '0;
            end
        end
        else
        begin
            rd_v_reg <= cmd.scan;
            if (cmd.capture)
            begin
                primed_reg  <= 1'b1;
                mul_cnt_reg <= '0;
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    prev_reg[l] <= s_tdata[l * CNT_W +: CNT_W];
                end
            end
            if (cmd.mul_en)
                mul_cnt_reg <= mul_cnt_reg + 2'd1;
            if (cmd.scale)
            begin
                scan_cnt_reg <= '0;
                wr_ptr_reg   <= (wr_ptr_reg == AW'(WINDOW - 1)) ? '0 : wr_ptr_reg + AW'(1);
                // entries beyond the fill count were never written and read as zero
                if (fill_reg != (AW + 1)'(WINDOW))
                    fill_reg <= fill_reg + (AW + 1)'(1);
            end
            if (cmd.scan)
                scan_cnt_reg <= scan_cnt_reg + AW'(1);
            if (cmd.div_init)
            begin
                div_cnt_reg <= '0;
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    hold_reg[l] <= max_reg[l];
                end
            end
            if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                diff_reg[l] <= s_tdata[l * CNT_W +: CNT_W] - prev_reg[l];
            end
        end
        if (cmd.mul_en)
            prod_reg[mul_cnt_reg] <= mul_res;
        rd_fill_reg <= ({1'b0, scan_cnt_reg} < fill_reg);
        for (int l = 0; l < NUM_LANES; l++)
        begin
            if (cmd.scale)
            begin
                rate_reg[l] <= rate_new[l];
                min_reg[l]  <= RATE_SAT;
                max_reg[l]  <= global_max_reg ? hold_reg[l] : '0;
                sum_reg[l]  <= '0;
            end
            else if (rd_v_reg)
            begin
                if (hist_val[l] > max_reg[l])
                    max_reg[l] <= hist_val[l];
                if (hist_val[l] < min_reg[l])
                    min_reg[l] <= hist_val[l];
                sum_reg[l] <= sum_reg[l] + SUM_W'(hist_val[l]);
            end
            if (cmd.div_init)
            begin
                if (IS_POW2)
                begin
                    quot_reg[l] <= sum_reg[l][LOGW +: RATE_W];
                    rem_reg[l]  <= '0;
                end
                else
                begin
                    // high part is below WINDOW since the quotient fits 32 bits
                    rem_reg[l]  <= sum_reg[l][SUM_W-1:RATE_W];
                    quot_reg[l] <= sum_reg[l][RATE_W-1:0];
                end
            end
            else if (cmd.div_step)
            begin
                if (!div_cnt_reg[0])
                    qd_reg[l] <= div_prod[l][RCP_SH +: DIG_W];
                else
                begin
                    rem_reg[l]  <= div_rem[l][LOGW-1:0];
                    quot_reg[l] <= {quot_reg[l][DIG_W-1:0], qd_reg[l]};
                end
            end
        end
        if (cmd.load_out)
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                m_tdata_reg[l * 4 * RATE_W + 0 * RATE_W +: RATE_W] <= rate_reg[l];
                m_tdata_reg[l * 4 * RATE_W + 1 * RATE_W +: RATE_W] <= min_reg[l];
                m_tdata_reg[l * 4 * RATE_W + 2 * RATE_W +: RATE_W] <= hold_reg[l];
                m_tdata_reg[l * 4 * RATE_W + 3 * RATE_W +: RATE_W] <= quot_reg[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.load_out)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    wrs_ram #(
        .WIDTH (MEM_W),
        .DEPTH (WINDOW),
        .AW    (AW)
    ) u_hist_ram (
        .clk   (clk),
        .we    (cmd.scale),
        .waddr (wr_ptr_reg),
        .wdata (wr_data),
        .raddr (scan_cnt_reg),
        .rdata (rd_data)
    );

    assign status.primed    = primed_reg;
    assign status.mul_last  = (mul_cnt_reg == 2'd3);
    assign status.scan_last = (scan_cnt_reg == AW'(WINDOW - 1));
    assign status.div_skip  = IS_POW2;
    assign status.div_last  = (div_cnt_reg == 2'(AVG_STEPS - 1));
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== design/windowed_rate_statistics_unit.sv =====
// top level of the windowed rate statistics unit
// depends on wrs_pkg, wrs_ctrl, wrs_dp (which holds the wrs_ram history)
`timescale 1ns / 1ps

//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  s_*      | s_tvalid / s_tready | s_tdata: rx_count, tx_count
//  m_*      | m_tvalid / m_tready | m_tdata: rx rate/min/max/avg, tx same
//  cfg_*    | cfg_valid/cfg_ready | cfg_index, cfg_data (16 bits)
//
// the first word after reset only primes the block
// every later word passes the multiply, scale, scan, drain and divide steps and
// the output load before the next accept: one read per cycle scans the history
// ram, the multiply is one shared 32x16 unit over four partial products, and
// the average needs a reciprocal divide unless WINDOW is a power of two
// reset needs no clearing pass: a fill count makes unwritten entries read as zero
// a stalled result waits in the output register; a finished word holds only then

module windowed_rate_statistics_unit
    import wrs_pkg::*;
#(
    parameter int WINDOW = WRS_WINDOW
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // rx_count[63:0], tx_count[127:64]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // rx_rate, rx_min, rx_max, rx_avg,
                                             // tx_rate, tx_min, tx_max, tx_avg
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    wrs_cmd_t    cmd;
    wrs_status_t status;

    assign cfg_ready = 1'b1;

    wrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    wrs_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
